/* rtl/pms_pkg.sv */
package pms_pkg;

    // table geometry
    localparam int CHANNELS = 4;
    localparam int SLOTS    = 25;

    // field widths
    localparam int CH_W     = 2;
    localparam int ID_W     = 8;
    localparam int RATE_W   = 16;
    localparam int STAMP_W  = 32;
    localparam int CNT_W    = $clog2(SLOTS + 1);

    // period = DIV_NUM / rate
    localparam int DIV_NUM  = 1000;
    localparam int DIV_W    = $clog2(DIV_NUM + 1);
    localparam int DCNT_W   = (DIV_W > 1) ? $clog2(DIV_W) : 1;

    typedef enum logic {
        CMD_REG  = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_UPDATED = 3'd0,
        ST_ADDED   = 3'd1,
        ST_FULL    = 3'd2,
        ST_DUE     = 3'd3,
        ST_NONE    = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd                command;
        logic [CH_W-1:0]     channel;
        logic [ID_W-1:0]     msg_id;
        logic [RATE_W-1:0]   rate_hz;
        logic                start_enabled;
        logic [STAMP_W-1:0]  now_ms;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]     msg_id_out;
        t_status             status;
        logic                last;
    } t_out_item;

    // one stored periodic message
    typedef struct packed {
        logic [ID_W-1:0]     msg_id;
        logic                enabled;
        logic [RATE_W-1:0]   period;
        logic [STAMP_W-1:0]  stamp;
    } t_entry;

    // transaction walking down the cell chain
    typedef struct packed {
        t_cmd                command;
        logic [CH_W-1:0]     channel;
        logic [ID_W-1:0]     msg_id;
        logic                enabled;
        logic [RATE_W-1:0]   period;
        logic [STAMP_W-1:0]  stamp;
        logic [CNT_W-1:0]    rem;
        logic                past;
        logic                found;
        logic                added;
    } t_token;

    typedef struct packed {
        logic                valid;
        logic [ID_W-1:0]     msg_id;
    } t_emit;

endpackage

/* rtl/pms_div.sv */
module pms_div import pms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RATE_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_quot
);

    localparam logic [DIV_W-1:0] NUM = DIV_W'(DIV_NUM);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [RATE_W-1:0] r_div;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_quot;

    logic [DIV_W:0]    w_shift;
    logic [RATE_W-1:0] w_shift_ext;
    logic [RATE_W-1:0] w_diff;
    logic              w_ge;

    // one restoring step per cycle, msb first
    always_comb begin
        w_shift     = {r_rem, NUM[r_cnt]};
        w_shift_ext = RATE_W'(w_shift);
        w_ge        = (w_shift_ext >= r_div);
        w_diff      = w_shift_ext - r_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
            r_cnt  <= DCNT_W'(DIV_W - 1);
        end else if (r_busy) begin
            r_rem         <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
            r_quot[r_cnt] <= w_ge;
            r_cnt         <= r_cnt - DCNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* rtl/pms_cell.sv */
module pms_cell import pms_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_vld,
    input  t_token i_tok,
    output logic   o_vld,
    output t_token o_tok,
    output t_emit  o_emit
);

    // one slot of every channel's table
    t_entry r_tab [CHANNELS];
    logic   r_vld;
    t_token r_tok;
    t_token n_tok;

    t_entry             w_ent;
    logic               w_in_range;
    logic               w_match;
    logic               w_append;
    logic               w_due;
    logic               w_is_reg;
    logic [STAMP_W-1:0] w_age;

    // slot decisions for the passing transaction
    always_comb begin
        w_ent      = r_tab[i_tok.channel];
        w_is_reg   = (i_tok.command == CMD_REG);
        w_in_range = (i_tok.rem != '0);
        w_match    = w_in_range && (w_ent.msg_id == i_tok.msg_id) && !i_tok.found;
        w_append   = !w_in_range && !i_tok.past && !i_tok.found;
        w_age      = i_tok.stamp - w_ent.stamp;
        w_due      = w_in_range && w_ent.enabled && (w_age >= STAMP_W'(w_ent.period));

        n_tok      = i_tok;
        n_tok.rem  = w_in_range ? (i_tok.rem - CNT_W'(1)) : '0;
        n_tok.past = i_tok.past | !w_in_range;
        if (w_is_reg) begin
            n_tok.found = i_tok.found | w_match;
            n_tok.added = i_tok.added | w_append;
        end
    end

    // hand off to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_tok <= n_tok;
        end
    end

    // slot update
    always_ff @(posedge i_clk) begin
        if (i_en && i_vld) begin
            if (w_is_reg && (w_match || w_append)) begin
                r_tab[i_tok.channel].msg_id  <= i_tok.msg_id;
                r_tab[i_tok.channel].enabled <= i_tok.enabled;
                r_tab[i_tok.channel].period  <= i_tok.period;
                r_tab[i_tok.channel].stamp   <= i_tok.stamp;
            end else if (!w_is_reg && w_due) begin
                r_tab[i_tok.channel].stamp   <= i_tok.stamp;
            end
        end
    end

    assign o_vld         = r_vld;
    assign o_tok         = r_tok;
    assign o_emit.valid  = i_vld && !w_is_reg && w_due;
    assign o_emit.msg_id = w_ent.msg_id;

endmodule

/* rtl/periodic_message_scheduler_core.sv */
// Periodic message scheduler: one table of periodic messages per channel.
// Input channel i_valid/o_ready carries t_in_item transactions; output
// channel o_valid/i_ready carries t_out_item transactions.
// A register command (command 0) computes period = 1000 / rate_hz in an
// iterative divider (one quotient bit per cycle), then walks the cell chain
// to update the first entry with the same id or append a new one; it
// returns one result with last set.
// A tick command (command 1) walks the chain directly; every due entry
// emits one result in table order, the final one marked last, or a single
// nothing-due result when none is due.
// The table lives in a row of SLOTS cells, one slot of every channel per
// cell; a transaction moves one cell per cycle while the output is not
// stalled. A register command enters the chain after the divider's done
// pulse. One transaction is worked at a time; o_ready rises with the last
// result, so the next item is accepted only once the last one is through.
// Results pass through an output register; while the receiver holds
// i_ready low with a result waiting, the chain freezes and nothing is lost.
// Reset clears the entry counts of all channels; table contents are only
// ever read below the count and need no clearing.
module periodic_message_scheduler_core import pms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_in,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SCAN
    } t_state;

    t_state           r_state, n_state;
    t_in_item         r_item,  n_item;
    logic             r_inj_vld, n_inj_vld;
    t_token           r_inj_tok, n_inj_tok;
    logic [CNT_W-1:0] r_count [CHANNELS];
    logic [CNT_W-1:0] n_count [CHANNELS];
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    logic             r_pend_vld, n_pend_vld;
    logic [ID_W-1:0]  r_pend_id, n_pend_id;

    logic [SLOTS:0]   w_vld;
    t_token           w_tok  [SLOTS+1];
    t_emit            w_emit [SLOTS];
    logic             w_en;
    logic             w_accept;
    logic             w_finish;
    logic             w_emit_any;
    logic [ID_W-1:0]  w_emit_id;
    logic             w_div_done;
    logic [DIV_W-1:0] w_quot;
    t_in_item         w_lau_item;
    logic             w_ch_ok;
    logic [CNT_W-1:0] w_n;
    t_token           w_lau_tok;
    t_token           w_end_tok;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_en     = !r_out_valid || i_ready;

    // period divider
    pms_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept && (i_in.command == CMD_REG)),
        .i_divisor (i_in.rate_hz),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    // chain of table cells
    assign w_vld[0] = r_inj_vld;
    assign w_tok[0] = r_inj_tok;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        pms_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_tok   (w_tok[g]),
            .o_vld   (w_vld[g+1]),
            .o_tok   (w_tok[g+1]),
            .o_emit  (w_emit[g])
        );
    end

    // at most one cell holds the transaction, so or the emits together
    always_comb begin
        w_emit_any = 1'b0;
        w_emit_id  = '0;
        for (int k = 0; k < SLOTS; k++) begin
            w_emit_any = w_emit_any | w_emit[k].valid;
            w_emit_id  = w_emit_id | (w_emit[k].valid ? w_emit[k].msg_id : '0);
        end
    end

    // build the transaction that enters the chain
    always_comb begin
        w_lau_item = (r_state == S_IDLE) ? i_in : r_item;
        w_ch_ok    = (int'(w_lau_item.channel) < CHANNELS);
        w_n        = w_ch_ok ? r_count[w_lau_item.channel] : '0;

        w_lau_tok.command = w_lau_item.command;
        w_lau_tok.channel = w_lau_item.channel;
        w_lau_tok.msg_id  = w_lau_item.msg_id;
        w_lau_tok.enabled = w_lau_item.start_enabled;
        w_lau_tok.period  = (w_lau_item.rate_hz == '0) ? '1 : RATE_W'(w_quot);
        w_lau_tok.stamp   = (w_lau_item.command == CMD_REG)
                          ? (w_lau_item.now_ms + STAMP_W'(w_n)) : w_lau_item.now_ms;
        w_lau_tok.rem     = w_n;
        w_lau_tok.past    = !w_ch_ok;
        w_lau_tok.found   = 1'b0;
        w_lau_tok.added   = 1'b0;
    end

    assign w_end_tok = w_tok[SLOTS];
    assign w_finish  = w_vld[SLOTS] && w_en;

    // control and result sequencing
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_inj_vld   = r_inj_vld;
        n_inj_tok   = r_inj_tok;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_pend_vld  = r_pend_vld;
        n_pend_id   = r_pend_id;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_en) begin
            n_inj_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_item = i_in;
                    if (i_in.command == CMD_TICK) begin
                        n_inj_vld = 1'b1;
                        n_inj_tok = w_lau_tok;
                        n_state   = S_SCAN;
                    end else begin
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_inj_vld = 1'b1;
                    n_inj_tok = w_lau_tok;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // hold back each due id until the next one shows up or the scan ends
                if (w_en && w_emit_any) begin
                    if (r_pend_vld) begin
                        n_out_valid      = 1'b1;
                        n_out.msg_id_out = r_pend_id;
                        n_out.status     = ST_DUE;
                        n_out.last       = 1'b0;
                    end
                    n_pend_vld = 1'b1;
                    n_pend_id  = w_emit_id;
                end
                if (w_finish) begin
                    n_out_valid = 1'b1;
                    n_out.last  = 1'b1;
                    n_pend_vld  = 1'b0;
                    n_state     = S_IDLE;
                    if (w_end_tok.command == CMD_REG) begin
                        n_out.msg_id_out = w_end_tok.msg_id;
                        if (w_end_tok.found) begin
                            n_out.status = ST_UPDATED;
                        end else if (w_end_tok.added) begin
                            n_out.status = ST_ADDED;
                            n_count[w_end_tok.channel] =
                                r_count[w_end_tok.channel] + CNT_W'(1);
                        end else begin
                            n_out.status = ST_FULL;
                        end
                    end else if (r_pend_vld) begin
                        n_out.msg_id_out = r_pend_id;
                        n_out.status     = ST_DUE;
                    end else begin
                        n_out.msg_id_out = '0;
                        n_out.status     = ST_NONE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inj_vld   <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend_vld  <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_count[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_inj_vld   <= n_inj_vld;
            r_out_valid <= n_out_valid;
            r_pend_vld  <= n_pend_vld;
            r_count     <= n_count;
        end
        r_item    <= n_item;
        r_inj_tok <= n_inj_tok;
        r_out     <= n_out;
        r_pend_id <= n_pend_id;
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld))
        else $error("more than one transaction in the cell chain");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (w_vld == '0) && !r_pend_vld)
        else $error("ready while a transaction is still in flight");

    a_pend_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_state == S_SCAN))
        else $error("held due id outside a scan");

    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> o_valid && o_out.last)
        else $error("scan end without a final result");
`endif

endmodule

/* tb/pms_schedule_checker.sv */
`timescale 1ns / 100ps

module pms_schedule_checker import pms_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out,
    output int unsigned o_errors,
    output int unsigned o_pending,
    output int unsigned o_regs,
    output int unsigned o_ticks,
    output int unsigned o_due,
    output int unsigned o_full
);

    // shadow copy of the per-channel message tables
    t_entry      slot_tab [CHANNELS][SLOTS];
    int unsigned used [CHANNELS];

    // replies still owed by the block, oldest first
    t_out_item   reply_q [$];

    always @(posedge i_clk) begin : watch
        t_out_item          want;
        t_out_item          rep;
        t_entry             ent;
        logic [STAMP_W-1:0] age;
        int unsigned        n;
        int unsigned        hits;
        bit                 placed;
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) used[c] = 0;
            reply_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
            o_regs    <= 0;
            o_ticks   <= 0;
            o_due     <= 0;
            o_full    <= 0;
        end else begin
            // result transaction against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected result: id %0d status %0d last %b",
                             $time, i_out.msg_id_out, i_out.status, i_out.last);
                    o_errors <= o_errors + 1;
                end else begin
                    want = reply_q.pop_front();
                    if (i_out.msg_id_out !== want.msg_id_out || i_out.status !== want.status
                        || i_out.last !== want.last) begin
                        $display("%0t: mismatch: expected id %0d status %0d last %b, got id %0d status %0d last %b",
                                 $time, want.msg_id_out, want.status, want.last,
                                 i_out.msg_id_out, i_out.status, i_out.last);
                        o_errors <= o_errors + 1;
                    end
                    if (want.status == ST_DUE) o_due <= o_due + 1;
                    if (want.status == ST_FULL) o_full <= o_full + 1;
                end
            end

            // input transaction: update the shadow table, queue the replies
            if (i_in_valid && i_in_ready) begin
                if (i_in.command == CMD_REG) o_regs <= o_regs + 1;
                else o_ticks <= o_ticks + 1;

                if (int'(i_in.channel) >= CHANNELS) begin
                    // channel with no table
                    rep.msg_id_out = (i_in.command == CMD_REG) ? i_in.msg_id : '0;
                    rep.status     = (i_in.command == CMD_REG) ? ST_FULL : ST_NONE;
                    rep.last       = 1'b1;
                    reply_q.push_back(rep);
                end else if (i_in.command == CMD_REG) begin
                    n           = used[i_in.channel];
                    ent.msg_id  = i_in.msg_id;
                    ent.enabled = i_in.start_enabled;
                    ent.period  = (i_in.rate_hz == '0) ? '1
                                : RATE_W'(DIV_NUM / int'(i_in.rate_hz));
                    ent.stamp   = i_in.now_ms + STAMP_W'(n);
                    rep.msg_id_out = i_in.msg_id;
                    rep.last       = 1'b1;
                    // first entry with the same id gets overwritten
                    placed = 1'b0;
                    for (int k = 0; k < SLOTS; k++) begin
                        if (!placed && k < n && slot_tab[i_in.channel][k].msg_id == i_in.msg_id) begin
                            slot_tab[i_in.channel][k] = ent;
                            placed = 1'b1;
                        end
                    end
                    if (placed) begin
                        rep.status = ST_UPDATED;
                    end else if (n < SLOTS) begin
                        slot_tab[i_in.channel][n] = ent;
                        used[i_in.channel]        = n + 1;
                        rep.status                = ST_ADDED;
                    end else begin
                        rep.status = ST_FULL;
                    end
                    reply_q.push_back(rep);
                end else begin
                    // tick scan in table order
                    n    = used[i_in.channel];
                    hits = 0;
                    for (int k = 0; k < SLOTS; k++) begin
                        if (k < n && slot_tab[i_in.channel][k].enabled) begin
                            age = i_in.now_ms - slot_tab[i_in.channel][k].stamp;
                            if (age >= STAMP_W'(slot_tab[i_in.channel][k].period)) begin
                                slot_tab[i_in.channel][k].stamp = i_in.now_ms;
                                rep.msg_id_out = slot_tab[i_in.channel][k].msg_id;
                                rep.status     = ST_DUE;
                                rep.last       = 1'b0;
                                reply_q.push_back(rep);
                                hits++;
                            end
                        end
                    end
                    if (hits == 0) begin
                        rep.msg_id_out = '0;
                        rep.status     = ST_NONE;
                        rep.last       = 1'b1;
                        reply_q.push_back(rep);
                    end else begin
                        // mark the final due message
                        rep      = reply_q.pop_back();
                        rep.last = 1'b1;
                        reply_q.push_back(rep);
                    end
                end
            end
            o_pending <= reply_q.size();
        end
    end

endmodule

/* tb/periodic_message_scheduler_core_tb.sv */
`timescale 1ns / 100ps

module periodic_message_scheduler_core_tb;
    import pms_pkg::*;

    localparam int RANDOM_ITEMS = 220;
    localparam int FILL_AT      = 40;
    localparam int HOLD_AFTER   = 80;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_in;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_out;

    int unsigned err_cnt;
    int unsigned pend_cnt;
    int unsigned reg_cnt;
    int unsigned tick_cnt;
    int unsigned due_cnt;
    int unsigned full_cnt;

    // accepted input transactions so far
    int unsigned        sent_cnt;
    bit                 steady_send;
    logic [STAMP_W-1:0] wall_ms;

    periodic_message_scheduler_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

    pms_schedule_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_in        (i_in),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_out       (o_out),
        .o_errors    (err_cnt),
        .o_pending   (pend_cnt),
        .o_regs      (reg_cnt),
        .o_ticks     (tick_cnt),
        .o_due       (due_cnt),
        .o_full      (full_cnt)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // offer one transaction after a random gap, return once accepted
    task automatic send_item(input t_in_item item);
        int unsigned gap;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_send || roll < 60) gap = 0;
        else if (roll < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 40);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= item;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_cnt++;
    endtask

    task automatic send_reg(input int unsigned ch, input int unsigned id,
                            input int unsigned rate, input int unsigned en,
                            input logic [STAMP_W-1:0] now);
        t_in_item item;
        item.command       = CMD_REG;
        item.channel       = CH_W'(ch);
        item.msg_id        = ID_W'(id);
        item.rate_hz       = RATE_W'(rate);
        item.start_enabled = 1'(en);
        item.now_ms        = now;
        send_item(item);
    endtask

    // unused fields of a tick carry random content
    task automatic send_tick(input int unsigned ch, input logic [STAMP_W-1:0] now);
        t_in_item item;
        item.command       = CMD_TICK;
        item.channel       = CH_W'(ch);
        item.msg_id        = ID_W'($urandom);
        item.rate_hz       = RATE_W'($urandom);
        item.start_enabled = 1'($urandom_range(0, 1));
        item.now_ms        = now;
        send_item(item);
    endtask

    // mostly short periods so that ticks find due messages
    function automatic int unsigned pick_rate();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return $urandom_range(100, 1000);
        if (roll < 70) return $urandom_range(1001, 65535);
        if (roll < 85) return $urandom_range(1, 99);
        if (roll < 92) return 0;
        return $urandom_range(0, 65535);
    endfunction

    // small steps of system time, now and then a big jump
    task automatic advance_clock();
        if ($urandom_range(0, 99) < 3) wall_ms += $urandom;
        else wall_ms += STAMP_W'($urandom_range(0, 12));
    endtask

    // receiver: random stalls, calm stretches, one long hold
    initial begin
        int unsigned stall;
        int unsigned calm;
        int unsigned roll;
        bit          held;
        stall = 0;
        calm  = 0;
        held  = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sent_cnt >= HOLD_AFTER) begin
                // keep results back so the block fills and stalls its input
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_ready <= 1'b1;
            end else if (stall != 0) begin
                stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (calm != 0) begin
                    calm--;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3) calm = $urandom_range(50, 150);
                    else if (roll < 25) stall = $urandom_range(1, 3);
                    else if (roll < 28) stall = $urandom_range(8, 40);
                end
            end
        end
    end

    // stimulus and verdict
    initial begin
        t_in_item    item;
        int unsigned rnd_cnt;
        int unsigned roll;
        int unsigned ch;
        int unsigned id;
        int unsigned base;
        int unsigned nreg;
        int unsigned ntick;
        bit          filled;
        sent_cnt    = 0;
        steady_send = 1'b0;
        wall_ms     = '0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_in    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes and corner cases
        send_tick(0, 32'd0);                              // empty table
        send_reg(0, 8'h00, 16'd0, 1, 32'd0);              // rate zero, longest period
        send_reg(0, 8'hFF, 16'hFFFF, 1, 32'hFFFF_FFFF);   // period zero, stamp wraps
        send_reg(0, 8'h07, 16'd1000, 0, 32'd10);          // starts disabled
        send_reg(0, 8'h00, 16'd1, 1, 32'd20);             // same id, update
        send_tick(0, 32'd21);
        send_tick(0, 32'd21);
        send_reg(0, 8'h07, 16'd1001, 1, 32'd30);          // enabled by update
        send_tick(0, 32'd30);
        send_tick(0, 32'hAAAA_AAAA);                      // big jump forward
        send_tick(0, 32'h5555_5555);                      // time goes backwards
        send_reg(1, 8'hAA, 16'hAAAA, 1, 32'h5555_5555);
        send_reg(1, 8'h55, 16'h5555, 0, 32'hAAAA_AAAA);
        send_tick(1, 32'hFFFF_FFFF);
        send_reg(2, 8'h80, 16'd500, 1, 32'hFFFF_FFF0);    // period two across the wrap
        send_tick(2, 32'hFFFF_FFF2);
        send_tick(2, 32'h0000_0001);
        send_tick(2, 32'h0000_0002);
        send_tick(3, 32'd0);
        send_reg(3, 8'h01, 16'd999, 1, 32'd5);
        send_tick(3, 32'd6);

        // random traffic
        rnd_cnt = 0;
        filled  = 1'b0;
        wall_ms = 32'hFFFF_F000;
        while (rnd_cnt < RANDOM_ITEMS) begin
            steady_send = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (!filled && rnd_cnt >= FILL_AT) begin
                // fill one table past its capacity, then scan it
                filled = 1'b1;
                ch   = $urandom_range(0, CHANNELS - 1);
                base = $urandom_range(0, 255);
                for (int k = 0; k < SLOTS + 3; k++) begin
                    send_reg(ch, base + 7 * k, pick_rate(),
                             ($urandom_range(0, 9) != 0), wall_ms);
                    rnd_cnt++;
                end
                send_reg(ch, base, pick_rate(), 1, wall_ms);
                rnd_cnt++;
                for (int k = 0; k < 4; k++) begin
                    advance_clock();
                    send_tick(ch, wall_ms);
                    rnd_cnt++;
                end
            end else if (roll < 85) begin
                // well-formed: a few registrations, then ticks
                ch    = $urandom_range(0, CHANNELS - 1);
                nreg  = $urandom_range(0, 4);
                ntick = $urandom_range(1, 6);
                for (int k = 0; k < nreg; k++) begin
                    id = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 15);
                    send_reg(ch, id, pick_rate(), ($urandom_range(0, 6) != 0), wall_ms);
                    rnd_cnt++;
                end
                for (int k = 0; k < ntick; k++) begin
                    advance_clock();
                    send_tick(ch, wall_ms);
                    rnd_cnt++;
                end
            end else begin
                // noise: every field random
                for (int k = 0; k < $urandom_range(1, 3); k++) begin
                    item.command       = t_cmd'(1'($urandom_range(0, 1)));
                    item.channel       = CH_W'($urandom);
                    item.msg_id        = ID_W'($urandom);
                    item.rate_hz       = RATE_W'($urandom);
                    item.start_enabled = 1'($urandom_range(0, 1));
                    item.now_ms        = $urandom;
                    send_item(item);
                    rnd_cnt++;
                end
            end
        end
        i_valid <= 1'b0;

        // wait for every owed reply, then watch for strays
        @(posedge i_clk);
        while (pend_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d register and %0d tick transactions, one table driven past full.",
                 reg_cnt, tick_cnt);
        $display("Saw %0d due messages and %0d table-full replies, %0d mismatches.",
                 due_cnt, full_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
